// File: rtl/rlpf_pkg.sv
package rlpf_pkg;

   localparam int POS_W = 22;
   localparam int DEFL_W = 12;
   localparam int GAIN_W = 16;
   localparam int STEP_W = 16;
   localparam int TIME_W = 27;
   localparam int PER_W = 16;
   localparam int GAIN_SHIFT_DEF = 8;
   localparam int POS_LIMIT = 2000000;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // distance per axis fits 24 bits, squared sum fits 50 bits
   localparam int DIST_W = 24;
   localparam int SUM_W = 50;
   localparam int ROOT_W = 25;
   localparam int NUM_W = DIST_W + STEP_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 2'd2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GOAL,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage

// File: rtl/rate_limited_position_follower.sv
// start transaction: result valid the cycle after acceptance; tick transaction: goal update per axis,
// squared-distance sum, restoring square root, then a divide per axis (skipped at zero distance)
// throughput: one transaction at a time; the next is taken the cycle after the result is accepted
// the restoring square root and divide steps produce one result bit per cycle
// synchronous active-high reset clears positions, elapsed time and loads register defaults
module rate_limited_position_follower #(
   parameter int GAIN_SHIFT = rlpf_pkg::GAIN_SHIFT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [rlpf_pkg::POS_W-1:0]   req_meas_x,
   input  logic signed [rlpf_pkg::POS_W-1:0]   req_meas_y,
   input  logic signed [rlpf_pkg::POS_W-1:0]   req_meas_z,
   input  logic signed [rlpf_pkg::DEFL_W-1:0]  req_defl_x,
   input  logic signed [rlpf_pkg::DEFL_W-1:0]  req_defl_y,
   input  logic signed [rlpf_pkg::DEFL_W-1:0]  req_defl_z,
   input  logic        [rlpf_pkg::PER_W-1:0]   req_period_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rlpf_pkg::POS_W-1:0]   rsp_cmd_x,
   output logic signed [rlpf_pkg::POS_W-1:0]   rsp_cmd_y,
   output logic signed [rlpf_pkg::POS_W-1:0]   rsp_cmd_z,
   output logic                                rsp_finished,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [rlpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [rlpf_pkg::CSR_DATA_W-1:0] csr_data
);
   import rlpf_pkg::*;

   localparam int PROD_W = DEFL_W + GAIN_W + 1;
   localparam int GSUM_W = PROD_W + 2;

   state_type state_ff, state_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] dur_ff, dur_in;
   logic signed [POS_W-1:0] goal_ff [3];
   logic signed [POS_W-1:0] goal_in [3];
   logic signed [POS_W-1:0] cmd_ff [3];
   logic signed [POS_W-1:0] cmd_in [3];
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic signed [DEFL_W-1:0] defl_ff [3];
   logic signed [DEFL_W-1:0] defl_in [3];
   logic [1:0] axis_ff, axis_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic fin_ff, fin_in;

   logic signed [PROD_W-1:0] prod;
   logic signed [GSUM_W-1:0] inc, gsum;
   logic signed [DIST_W-1:0] delta;
   logic [DIST_W-1:0] adist;
   logic [2*DIST_W-1:0] sq;
   logic [SUM_W+1:0] trial;
   logic [SUM_W+1:0] remsh;
   logic [ROOT_W+1:0] dtrial;
   logic [ROOT_W+1:0] drem;
   logic signed [DIST_W+1:0] nsum;
   logic [TIME_W:0] tsum;

   function automatic logic signed [POS_W-1:0] clamp(input logic signed [GSUM_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > GSUM_W'(POS_LIMIT)) r = POS_W'(POS_LIMIT);
      else if (v < -GSUM_W'(POS_LIMIT)) r = -POS_W'(POS_LIMIT);
      else r = v[POS_W-1:0];
      return r;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_cmd_x = cmd_ff[0];
   assign rsp_cmd_y = cmd_ff[1];
   assign rsp_cmd_z = cmd_ff[2];
   assign rsp_finished = fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gain_ff <= GAIN_W'(256);
         step_ff <= STEP_W'(1000);
         dur_ff <= TIME_W'(10000000);
         elapsed_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            goal_ff[i] <= '0;
            cmd_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         gain_ff <= gain_in;
         step_ff <= step_in;
         dur_ff <= dur_in;
         elapsed_ff <= elapsed_in;
         goal_ff <= goal_in;
         cmd_ff <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      defl_ff <= defl_in;
      axis_ff <= axis_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      fin_ff <= fin_in;
   end

   always_comb begin
      state_in = state_ff;
      gain_in = gain_ff;
      step_in = step_ff;
      dur_in = dur_ff;
      elapsed_in = elapsed_ff;
      goal_in = goal_ff;
      cmd_in = cmd_ff;
      defl_in = defl_ff;
      axis_in = axis_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      fin_in = fin_ff;

      prod = PROD_W'(defl_ff[axis_ff]) * $signed({1'b0, gain_ff});
      inc = GSUM_W'(prod >>> GAIN_SHIFT);
      gsum = GSUM_W'(goal_ff[axis_ff]) + inc;
      delta = DIST_W'(goal_ff[axis_ff]) - DIST_W'(cmd_ff[axis_ff]);
      adist = delta[DIST_W-1] ? DIST_W'(-delta) : DIST_W'(delta);
      sq = adist * adist;
      // restoring square root, one result bit per cycle
      remsh = {rem_ff, acc_ff[SUM_W-1 -: 2]};
      trial = {root_ff, 2'b01};
      // restoring divide by root, one quotient bit per cycle
      drem = {acc_ff[ROOT_W:0], num_ff[NUM_W-1]};
      dtrial = drem - {1'b0, root_ff};
      nsum = (DIST_W+2)'(cmd_ff[axis_ff])
           + (delta[DIST_W-1] ? -$signed((DIST_W+2)'(quo_ff))
                              : $signed((DIST_W+2)'(quo_ff)));
      tsum = {1'b0, elapsed_ff} + (TIME_W+1)'(req_period_us);

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_GAIN: gain_in = csr_data[GAIN_W-1:0];
                  CSR_STEP: step_in = csr_data[STEP_W-1:0];
                  CSR_DURATION: dur_in = csr_data[TIME_W-1:0];
                  default: ;
               endcase
            end
            if (req_valid) begin
               if (req_operation == OP_START) begin
                  goal_in[0] = clamp(GSUM_W'(req_meas_x));
                  goal_in[1] = clamp(GSUM_W'(req_meas_y));
                  goal_in[2] = clamp(GSUM_W'(req_meas_z));
                  cmd_in = goal_in;
                  elapsed_in = '0;
                  fin_in = (dur_ff == '0);
                  state_in = ST_RESP;
               end else begin
                  defl_in[0] = req_defl_x;
                  defl_in[1] = req_defl_y;
                  defl_in[2] = req_defl_z;
                  elapsed_in = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
                  axis_in = 2'd0;
                  state_in = ST_GOAL;
               end
            end
         end
         ST_GOAL: begin
            goal_in[axis_ff] = clamp(gsum);
            if (axis_ff == 2'd2) begin
               axis_in = 2'd0;
               acc_in = '0;
               state_in = ST_SQUARE;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_SQUARE: begin
            acc_in = acc_ff + SUM_W'(sq);
            if (axis_ff == 2'd2) begin
               rem_in = '0;
               root_in = '0;
               cnt_in = 6'(ROOT_W);
               state_in = ST_SQRT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            acc_in = acc_ff << 2;
            if (remsh >= trial) begin
               rem_in = SUM_W'(remsh - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in = SUM_W'(remsh);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               if (root_in == '0) begin
                  fin_in = (elapsed_ff >= dur_ff);
                  state_in = ST_RESP;
               end else begin
                  axis_in = 2'd0;
                  state_in = ST_DIV;
                  cnt_in = '0;
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               num_in = NUM_W'(adist * step_ff) + NUM_W'(root_ff >> 1);
               acc_in = '0;
               quo_in = '0;
               cnt_in = 6'(NUM_W);
            end else begin
               num_in = num_ff << 1;
               if (!dtrial[ROOT_W+1]) begin
                  acc_in = SUM_W'(dtrial[ROOT_W:0]);
                  quo_in = {quo_ff[NUM_W-2:0], 1'b1};
               end else begin
                  acc_in = SUM_W'(drem[ROOT_W:0]);
                  quo_in = {quo_ff[NUM_W-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 6'd1;
            end
            if (cnt_ff == 6'd1) begin
               cnt_in = 6'd63;
            end
            if (cnt_ff == 6'd63) begin
               cmd_in[axis_ff] = clamp(GSUM_W'(nsum));
               cnt_in = '0;
               if (axis_ff == 2'd2) begin
                  fin_in = (elapsed_ff >= dur_ff);
                  state_in = ST_RESP;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/rlpf_checker.sv
module rlpf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_operation,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_finished,
   input logic csr_ready,
   input logic signed [rlpf_pkg::POS_W-1:0] rsp_cmd_x
);
   import rlpf_pkg::*;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready while busy");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && (req_ready || csr_ready))) else $error("result and ready together");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_START |=> rsp_valid)
      else $error("start result late");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cmd_x) && $stable(rsp_finished))
      else $error("result dropped");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cmd_x <= POS_W'(POS_LIMIT) && rsp_cmd_x >= -POS_W'(POS_LIMIT))
      else $error("position out of range");

endmodule

bind rate_limited_position_follower rlpf_checker u_rlpf_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_operation(req_operation), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_finished(rsp_finished), .csr_ready(csr_ready), .rsp_cmd_x(rsp_cmd_x)
);

// File: verif/rate_limited_position_follower_checker.sv
module rate_limited_position_follower_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [rlpf_pkg::POS_W-1:0]    req_meas_x,
   input  logic signed [rlpf_pkg::POS_W-1:0]    req_meas_y,
   input  logic signed [rlpf_pkg::POS_W-1:0]    req_meas_z,
   input  logic signed [rlpf_pkg::DEFL_W-1:0]   req_defl_x,
   input  logic signed [rlpf_pkg::DEFL_W-1:0]   req_defl_y,
   input  logic signed [rlpf_pkg::DEFL_W-1:0]   req_defl_z,
   input  logic        [rlpf_pkg::PER_W-1:0]    req_period_us,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [rlpf_pkg::POS_W-1:0]    rsp_cmd_x,
   input  logic signed [rlpf_pkg::POS_W-1:0]    rsp_cmd_y,
   input  logic signed [rlpf_pkg::POS_W-1:0]    rsp_cmd_z,
   input  logic                                 rsp_finished,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic        [rlpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [rlpf_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                   fail_count,
   output int                                   pending_count
);
   import rlpf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic                    finished;
   } position_report_type;

   position_report_type expected_reports[$];
   longint goal_gain, step_length, duration;
   longint goal[3], cmd[3];
   longint elapsed;

   function automatic longint clamp_limit(longint v);
      if (v > POS_LIMIT) return POS_LIMIT;
      if (v < -POS_LIMIT) return -POS_LIMIT;
      return v;
   endfunction

   function automatic longint int_root(longint n);
      longint r;
      r = 0;
      for (int b = 30; b >= 0; b--) begin
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n) r = r + (longint'(1) << b);
      end
      return r;
   endfunction

   function automatic longint floor_gain_shift(longint p);
      if (p >= 0) return p >>> GAIN_SHIFT_DEF;
      return -((-p + (longint'(1) << GAIN_SHIFT_DEF) - 1) >>> GAIN_SHIFT_DEF);
   endfunction

   task automatic follow_item(logic op, longint mx, longint my, longint mz,
                              longint dx, longint dy, longint dz, longint per);
      longint meas[3], defl[3], d[3], sum, mag, a, q;
      position_report_type r;
      meas = '{mx, my, mz};
      defl = '{dx, dy, dz};
      if (op == OP_START) begin
         for (int i = 0; i < 3; i++) begin
            goal[i] = clamp_limit(meas[i]);
            cmd[i] = goal[i];
         end
         elapsed = 0;
      end else begin
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            goal[i] = clamp_limit(goal[i] + floor_gain_shift(defl[i] * goal_gain));
            d[i] = goal[i] - cmd[i];
            sum += d[i] * d[i];
         end
         mag = int_root(sum);
         if (mag != 0) begin
            for (int i = 0; i < 3; i++) begin
               a = d[i] < 0 ? -d[i] : d[i];
               q = (a * step_length + (mag >> 1)) / mag;
               cmd[i] = clamp_limit(cmd[i] + (d[i] < 0 ? -q : q));
            end
         end
         elapsed += per;
         if (elapsed > (longint'(1) << TIME_W) - 1) elapsed = (longint'(1) << TIME_W) - 1;
      end
      r.x = POS_W'(cmd[0]);
      r.y = POS_W'(cmd[1]);
      r.z = POS_W'(cmd[2]);
      r.finished = elapsed >= duration;
      expected_reports.push_back(r);
   endtask

   assign pending_count = expected_reports.size();

   always @(posedge clock) begin
      position_report_type e;
      if (reset) begin
         goal_gain <= 256;
         step_length <= 1000;
         duration <= 10000000;
         goal = '{0, 0, 0};
         cmd = '{0, 0, 0};
         elapsed = 0;
         expected_reports.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN: goal_gain <= csr_data[GAIN_W-1:0];
               CSR_STEP: step_length <= csr_data[STEP_W-1:0];
               CSR_DURATION: duration <= csr_data[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            follow_item(req_operation, req_meas_x, req_meas_y, req_meas_z,
                        req_defl_x, req_defl_y, req_defl_z, req_period_us);
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t unexpected transaction: %0d %0d %0d %0d", $time,
                        rsp_cmd_x, rsp_cmd_y, rsp_cmd_z, rsp_finished);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_reports.pop_front();
               if (e != {rsp_cmd_x, rsp_cmd_y, rsp_cmd_z, rsp_finished}) begin
                  $display("%0t mismatch: expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                           $time, e.x, e.y, e.z, e.finished,
                           rsp_cmd_x, rsp_cmd_y, rsp_cmd_z, rsp_finished);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: verif/rate_limited_position_follower_tb.sv
module rate_limited_position_follower_tb;
   import rlpf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, req_operation = 0;
   logic signed [POS_W-1:0] req_meas_x = 0, req_meas_y = 0, req_meas_z = 0;
   logic signed [DEFL_W-1:0] req_defl_x = 0, req_defl_y = 0, req_defl_z = 0;
   logic [PER_W-1:0] req_period_us = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [POS_W-1:0] rsp_cmd_x, rsp_cmd_y, rsp_cmd_z;
   logic rsp_finished;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;
   int fail_count, pending_count;
   int send_idle_pct = 0, recv_idle_pct = 0;
   longint cycle_count = 0;

   always #5 clock = ~clock;

   rate_limited_position_follower DUT (.*);
   rate_limited_position_follower_checker checker_0 (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_item(logic op, logic signed [POS_W-1:0] mx, my, mz,
                            logic signed [DEFL_W-1:0] dx, dy, dz, logic [PER_W-1:0] per);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1;
      req_operation <= op;
      req_meas_x <= mx;
      req_meas_y <= my;
      req_meas_z <= mz;
      req_defl_x <= dx;
      req_defl_y <= dy;
      req_defl_z <= dz;
      req_period_us <= per;
      do @(posedge clock); while (!req_ready);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic logic signed [POS_W-1:0] rand_pos();
      case ($urandom_range(3))
         0: return POS_W'($urandom_range(4000)) - POS_W'(2000);
         1: return POS_W'(POS_LIMIT);
         2: return -POS_W'(POS_LIMIT);
         default: return POS_W'($urandom_range(4000000)) - POS_W'(2000000);
      endcase
   endfunction

   task automatic random_run(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0)
            send_item(OP_START, rand_pos(), rand_pos(), rand_pos(), DEFL_W'($urandom),
                      DEFL_W'($urandom), DEFL_W'($urandom), PER_W'($urandom));
         else if ($urandom_range(9) == 0)
            send_item(OP_TICK, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      0, 0, 0, PER_W'($urandom));
         else
            send_item(OP_TICK, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                      DEFL_W'($urandom), DEFL_W'($urandom), DEFL_W'($urandom),
                      PER_W'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset defaults, extremes, zero distance, saturation
      send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      send_item(OP_START, 22'sh1FFFFF, 22'sh200000, 5, 0, 0, 0, 0);
      send_item(OP_TICK, 0, 0, 0, 2047, -2048, 0, 16'hFFFF);
      send_item(OP_TICK, 0, 0, 0, 2047, 2047, 2047, 16'hFFFF);
      send_item(OP_START, -POS_W'(POS_LIMIT), POS_W'(POS_LIMIT), 0, 0, 0, 0, 0);
      send_item(OP_TICK, 0, 0, 0, -2048, 2047, -1, 1);
      send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      write_reg(CSR_GAIN, 65535);
      write_reg(CSR_STEP, 65535);
      write_reg(CSR_DURATION, 0);
      write_reg(CSR_UNUSED, 32'hFFFFFFFF);
      send_item(OP_START, 0, 0, 0, 0, 0, 0, 0);
      send_item(OP_TICK, 0, 0, 0, 2047, -2048, 2047, 0);
      send_item(OP_TICK, 0, 0, 0, -2048, -2048, -2048, 16'hFFFF);
      send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
      write_reg(CSR_GAIN, 0);
      write_reg(CSR_STEP, 0);
      write_reg(CSR_DURATION, 32'hFFFFFFFF);
      send_item(OP_TICK, 0, 0, 0, 1, 1, 1, 16'hFFFF);
      for (int i = 0; i < 600; i++) send_item(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF);
      write_reg(CSR_GAIN, 256);
      write_reg(CSR_STEP, 1000);
      write_reg(CSR_DURATION, 100000000);
      // random phases with varying registers
      send_idle_pct = 7;
      recv_idle_pct = 56;
      random_run(250);
      // pause until drained
      while (pending_count != 0) @(posedge clock);
      write_reg(CSR_GAIN, $urandom);
      write_reg(CSR_STEP, $urandom);
      write_reg(CSR_DURATION, $urandom_range(2000000));
      send_idle_pct = 56;
      recv_idle_pct = 7;
      random_run(250);
      write_reg(CSR_GAIN, $urandom_range(65535, 60000));
      write_reg(CSR_STEP, $urandom_range(100));
      write_reg(CSR_DURATION, $urandom_range(300000));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_run(300);
      while (pending_count != 0 && cycle_count < 1900000) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/rlpf_pkg.sv
rtl/rate_limited_position_follower.sv
rtl/rlpf_checker.sv
verif/rate_limited_position_follower_checker.sv
verif/rate_limited_position_follower_tb.sv
